[sv/hfyuv_pkg.sv]
// Types, constants and helper functions for the half-float RGB to YUV converter.
// Used by hfyuv_decode, hfyuv_row and half_float_rgb_to_yuv_top; no dependencies.
package hfyuv_pkg;

    // Pixel payloads on the two channels
    typedef struct packed {
        logic [15:0] red_half;
        logic [15:0] green_half;
        logic [15:0] blue_half;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } pix_out_t;

    // Widths of the datapath
    localparam int BASE_W  = 19;   // mantissa * 255, after right alignment
    localparam int SHIFT_W = 6;    // left shift 0..32
    localparam int COEF_W  = 16;   // coefficient magnitude, Q16
    localparam int PROD_W  = BASE_W + COEF_W;
    localparam int TERM_W  = 57;   // signed, aligned product in Q32
    localparam int SUM_W   = 60;   // signed row sum in Q32
    localparam int PASS_W  = 40;   // unsigned scaled channel in Q16
    localparam int OFS_W   = 8;

    // Half-float field codes
    localparam logic [4:0]         EXP_SPECIAL = 5'd31;
    localparam logic [4:0]         EXP_ALIGN   = 5'd9;
    localparam logic [SHIFT_W-1:0] INF_SHIFT   = 6'd32;
    localparam logic [BASE_W-1:0]  INF_BASE    = 19'd255;

    // One decoded channel: value = (neg ? -1 : 1) * (base << shift), Q16 times 255
    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [SHIFT_W-1:0] shift;
        logic               neg;
        logic               nan;
    } dec_t;

    // One output row of the matrix; index 0 is red, 1 green, 2 blue
    typedef struct packed {
        logic [2:0][COEF_W-1:0] mag;
        logic [2:0]             neg;
        logic [OFS_W-1:0]       offset;
    } coef_row_t;

    // Per-stage load enables of the matrix pipeline
    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
    } stage_ld_t;

    // Rec.601 studio-range rows, coefficients rounded to Q16
    localparam coef_row_t ROW_Y = '{
        mag:    {16'd6423, 16'd33030, 16'd16843},
        neg:    3'b000,
        offset: 8'd16
    };
    localparam coef_row_t ROW_CB = '{
        mag:    {16'd28770, 16'd19071, 16'd9699},
        neg:    3'b011,
        offset: 8'd128
    };
    localparam coef_row_t ROW_CR = '{
        mag:    {16'd4653, 16'd24117, 16'd28770},
        neg:    3'b110,
        offset: 8'd128
    };

    // Clamp a signed Q32 sum to 0..255 and truncate
    function automatic logic [7:0] clamp_q32(input logic signed [SUM_W-1:0] v);
        logic [7:0] res;
        if (v[SUM_W-1])
            res = 8'd0;
        else if (|v[SUM_W-2:40])
            res = 8'd255;
        else
            res = v[39:32];
        return res;
    endfunction

    // Clamp a sign-magnitude Q16 value to 0..255 and truncate
    function automatic logic [7:0] clamp_q16(input logic neg, input logic [PASS_W-1:0] mag);
        logic [7:0] res;
        if (neg)
            res = 8'd0;
        else if (|mag[PASS_W-1:24])
            res = 8'd255;
        else
            res = mag[23:16];
        return res;
    endfunction

endpackage

[sv/hfyuv_decode.sv]
// Binary16 decoder: splits one half-float into an aligned base times 255 and a left shift.
// Depends on hfyuv_pkg (dec_t and field constants).
module hfyuv_decode (
    input  logic [15:0]      half,
    output hfyuv_pkg::dec_t  dec
);
    import hfyuv_pkg::*;

    logic                sign;
    logic [4:0]          expo;
    logic [9:0]          frac;
    logic [4:0]          eff_expo;
    logic [10:0]         mant;
    logic [BASE_W-1:0]   mant255;

    assign sign     = half[15];
    assign expo     = half[14:10];
    assign frac     = half[9:0];

    // Subnormals use exponent 1 without the hidden bit
    assign eff_expo = (expo == 5'd0) ? 5'd1 : expo;
    assign mant     = (expo == 5'd0) ? {1'b0, frac} : {1'b1, frac};
    assign mant255  = {mant, 8'b0} - {8'b0, mant};

    always_comb
    begin
        dec.neg   = sign;
        dec.nan   = 1'b0;
        dec.base  = '0;
        dec.shift = '0;
        if (expo == EXP_SPECIAL)
        begin
            // infinity is 255 << 32; NaN decodes to zero with its flag set
            dec.nan = (frac != 10'd0);
            if (frac == 10'd0)
            begin
                dec.base  = INF_BASE;
                dec.shift = INF_SHIFT;
            end
        end
        else if (eff_expo >= EXP_ALIGN)
        begin
            dec.base  = mant255;
            dec.shift = SHIFT_W'(eff_expo - EXP_ALIGN);
        end
        else
        begin
            // small values: truncate the magnitude toward zero
            dec.base  = mant255 >> (EXP_ALIGN - eff_expo);
        end
    end

endmodule

[sv/hfyuv_row.sv]
// One output row of the color matrix: multiply, align, two-level add; four register stages.
// Depends on hfyuv_pkg (dec_t, coef_row_t, stage_ld_t, clamp_q32).
module hfyuv_row (
    input  logic                       clk,
    input  hfyuv_pkg::stage_ld_t       ctl,
    input  hfyuv_pkg::coef_row_t       coef,
    input  hfyuv_pkg::dec_t [2:0]      chan,
    output logic [7:0]                 sample
);
    import hfyuv_pkg::*;

    logic [PROD_W-1:0]         prod_reg  [3];
    logic [SHIFT_W-1:0]        shift_reg [3];
    logic                      neg_reg   [3];
    logic signed [TERM_W-1:0]  term_reg  [3];
    logic signed [TERM_W-1:0]  term_next [3];
    logic signed [SUM_W-1:0]   part_a_reg;
    logic signed [SUM_W-1:0]   part_b_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   part_a_next;
    logic signed [SUM_W-1:0]   part_b_next;
    logic        [TERM_W-1:0]  aligned   [3];

    // Stage 2: base times coefficient magnitude, sign of the term kept aside
    always_ff @(posedge clk)
    begin
        if (ctl.ld2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i]  <= PROD_W'(chan[i].base) * PROD_W'(coef.mag[i]);
                shift_reg[i] <= chan[i].shift;
                neg_reg[i]   <= chan[i].neg ^ coef.neg[i];
            end
        end
    end

    // Stage 3: align to Q32 and apply the sign
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            aligned[i]   = TERM_W'(prod_reg[i]) << shift_reg[i];
            term_next[i] = neg_reg[i] ? -aligned[i] : aligned[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld3)
        begin
            for (int i = 0; i < 3; i++)
                term_reg[i] <= term_next[i];
        end
    end

    // Stage 4: two partial sums, offset folded into the second
    assign part_a_next = {{(SUM_W-TERM_W){term_reg[0][TERM_W-1]}}, term_reg[0]}
                       + {{(SUM_W-TERM_W){term_reg[1][TERM_W-1]}}, term_reg[1]};
    assign part_b_next = {{(SUM_W-TERM_W){term_reg[2][TERM_W-1]}}, term_reg[2]}
                       + {{(SUM_W-OFS_W-32){1'b0}}, coef.offset, 32'b0};

    always_ff @(posedge clk)
    begin
        if (ctl.ld4)
        begin
            part_a_reg <= part_a_next;
            part_b_reg <= part_b_next;
        end
    end

    // Stage 5: final sum
    always_ff @(posedge clk)
    begin
        if (ctl.ld5)
            sum_reg <= part_a_reg + part_b_reg;
    end

    assign sample = clamp_q32(sum_reg);

endmodule

[sv/half_float_rgb_to_yuv_top.sv]
// Half-float RGB to 8-bit Rec.601 YUV converter, top level with pipeline control.
// Depends on hfyuv_pkg, hfyuv_decode and hfyuv_row.
// Pipeline registers from an input transfer to the result on dst: decode, multiply,
//   align, two adder levels, output register.
// Throughput: one pixel per clock while dst_stall is low; each stage holds its item only while the next is full.
// Reset: rst_n clears all stage valid bits and matrix_enable (pass-through).
module half_float_rgb_to_yuv_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  matrix_enable_we,
    input  logic                  matrix_enable_wdata,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  hfyuv_pkg::pix_in_t    src_pixel,
    output logic                  dst_valid,
    input  logic                  dst_stall,
    output hfyuv_pkg::pix_out_t   dst_pixel
);
    import hfyuv_pkg::*;

    logic          matrix_enable_reg;
    logic [5:1]    valid_reg;
    logic          dst_valid_reg;
    logic [6:1]    adv;
    stage_ld_t     row_ctl;

    dec_t [2:0]    dec_next;
    dec_t [2:0]    chan1_reg;
    logic [5:1]    mode_reg;
    logic [5:2]    nan_reg;
    pix_out_t      pass_reg [2:5];
    pix_out_t      pass_next;
    pix_out_t      mat_sample;
    pix_out_t      dst_pixel_reg;
    pix_out_t      dst_pixel_next;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            matrix_enable_reg <= 1'b0;
        else if (matrix_enable_we)
            matrix_enable_reg <= matrix_enable_wdata;
    end

    // Stage advance: a stage loads when it is empty or its successor loads
    always_comb
    begin
        adv[6] = !dst_valid_reg || !dst_stall;
        for (int i = 5; i >= 1; i--)
            adv[i] = !valid_reg[i] || adv[i+1];
    end

    assign src_stall = !adv[1];
    assign row_ctl   = '{ld2: adv[2], ld3: adv[3], ld4: adv[4], ld5: adv[5]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv[1])
                valid_reg[1] <= src_valid;
            for (int i = 2; i <= 5; i++)
            begin
                if (adv[i])
                    valid_reg[i] <= valid_reg[i-1];
            end
            if (adv[6])
                dst_valid_reg <= valid_reg[5];
        end
    end

    // Stage 1: decode the three channels
    hfyuv_decode u_dec_r (.half(src_pixel.red_half),   .dec(dec_next[0]));
    hfyuv_decode u_dec_g (.half(src_pixel.green_half), .dec(dec_next[1]));
    hfyuv_decode u_dec_b (.half(src_pixel.blue_half),  .dec(dec_next[2]));

    always_ff @(posedge clk)
    begin
        if (adv[1])
            chan1_reg <= dec_next;
    end

    // Stage 2: pass-through samples and NaN summary; carried along to the output
    assign pass_next.luma        = clamp_q16(chan1_reg[0].neg,
                                             PASS_W'(chan1_reg[0].base) << chan1_reg[0].shift);
    assign pass_next.chroma_blue = clamp_q16(chan1_reg[1].neg,
                                             PASS_W'(chan1_reg[1].base) << chan1_reg[1].shift);
    assign pass_next.chroma_red  = clamp_q16(chan1_reg[2].neg,
                                             PASS_W'(chan1_reg[2].base) << chan1_reg[2].shift);

    // Mode bit is taken with the input transfer and travels with its item
    always_ff @(posedge clk)
    begin
        if (adv[1])
            mode_reg[1] <= matrix_enable_reg;
        if (adv[2])
        begin
            pass_reg[2] <= pass_next;
            nan_reg[2]  <= chan1_reg[0].nan | chan1_reg[1].nan | chan1_reg[2].nan;
            mode_reg[2] <= mode_reg[1];
        end
        for (int i = 3; i <= 5; i++)
        begin
            if (adv[i])
            begin
                pass_reg[i] <= pass_reg[i-1];
                nan_reg[i]  <= nan_reg[i-1];
                mode_reg[i] <= mode_reg[i-1];
            end
        end
    end

    // Stages 2 to 5: one matrix row per output
    hfyuv_row u_row_y (
        .clk(clk), .ctl(row_ctl), .coef(ROW_Y),  .chan(chan1_reg), .sample(mat_sample.luma)
    );
    hfyuv_row u_row_cb (
        .clk(clk), .ctl(row_ctl), .coef(ROW_CB), .chan(chan1_reg),
        .sample(mat_sample.chroma_blue)
    );
    hfyuv_row u_row_cr (
        .clk(clk), .ctl(row_ctl), .coef(ROW_CR), .chan(chan1_reg),
        .sample(mat_sample.chroma_red)
    );

    // Stage 6: mode select into the output register
    always_comb
    begin
        if (!mode_reg[5])
            dst_pixel_next = pass_reg[5];
        else if (nan_reg[5])
            dst_pixel_next = '0;
        else
            dst_pixel_next = mat_sample;
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
            dst_pixel_reg <= dst_pixel_next;
    end

    assign dst_valid = dst_valid_reg;
    assign dst_pixel = dst_pixel_reg;

    // Checks
    logic src_xfer;
    logic dst_xfer;
    assign src_xfer = src_valid && !src_stall;
    assign dst_xfer = dst_valid_reg && !dst_stall;

    // a transfer in without one out adds exactly one item in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        src_xfer && !dst_xfer |=>
            $countones({valid_reg, dst_valid_reg})
                == $past($countones({valid_reg, dst_valid_reg})) + 1)
        else $error("item count did not grow on input transfer");

    // a transfer out without one in removes exactly one item
    assert property (@(posedge clk) disable iff (!rst_n)
        !src_xfer && dst_xfer |=>
            $countones({valid_reg, dst_valid_reg})
                == $past($countones({valid_reg, dst_valid_reg})) - 1)
        else $error("item count did not shrink on output transfer");

    // the input stalls only behind a full first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> valid_reg[1])
        else $error("input stalled with an empty first stage");

    // a full pipeline behind a stalled output must stall the input
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid_reg && dst_stall && (&valid_reg) |-> src_stall)
        else $error("input accepted into a full stalled pipeline");

endmodule

[dv/half_float_rgb_to_yuv_top_tb.sv]
// Self-checking testbench for half_float_rgb_to_yuv_top: random and directed binary16 pixels,
// with the YUV output checked against a bit-exact predictor in Q16/Q32 fixed point.
// Depends on hfyuv_pkg and the half_float_rgb_to_yuv_top RTL.
module half_float_rgb_to_yuv_top_tb;
    import hfyuv_pkg::*;

    // Rec.601 studio-range coefficients in Q16
    localparam longint Y_R  = 16843;
    localparam longint Y_G  = 33030;
    localparam longint Y_B  = 6423;
    localparam longint CR_R = 28770;
    localparam longint CR_G = -24117;
    localparam longint CR_B = -4653;
    localparam longint CB_R = -9699;
    localparam longint CB_G = -19071;
    localparam longint CB_B = 28770;
    localparam longint Y_OFS_Q32 = longint'(16) << 32;
    localparam longint C_OFS_Q32 = longint'(128) << 32;
    localparam longint INF_Q16   = longint'(255) << 32;
    localparam int     FRAC_Q16  = 16;
    localparam int     FRAC_Q32  = 32;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     HALF_PERIOD  = 10;

    // Binary16 patterns used by the directed part
    localparam logic [15:0] H_ZERO     = 16'h0000;
    localparam logic [15:0] H_NEG_ZERO = 16'h8000;
    localparam logic [15:0] H_ONE      = 16'h3C00;
    localparam logic [15:0] H_HALF     = 16'h3800;
    localparam logic [15:0] H_QUARTER  = 16'h3400;
    localparam logic [15:0] H_255      = 16'h5BF8;
    localparam logic [15:0] H_MAX      = 16'h7BFF;
    localparam logic [15:0] H_NEG_MAX  = 16'hFBFF;
    localparam logic [15:0] H_SUB_MIN  = 16'h0001;
    localparam logic [15:0] H_SUB_NEG  = 16'h8001;
    localparam logic [15:0] H_SUB_MAX  = 16'h03FF;
    localparam logic [15:0] H_INF      = 16'h7C00;
    localparam logic [15:0] H_NEG_INF  = 16'hFC00;
    localparam logic [15:0] H_QNAN     = 16'h7E00;
    localparam logic [15:0] H_SNAN     = 16'h7C01;
    localparam logic [15:0] H_NEG_NAN  = 16'hFE01;
    localparam logic [15:0] H_ALL_ONES = 16'hFFFF;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     matrix_enable_we = 1'b0;
    logic     matrix_enable_wdata = 1'b0;
    logic     src_valid = 1'b0;
    logic     src_stall;
    pix_in_t  src_pixel = '0;
    logic     dst_valid;
    logic     dst_stall = 1'b0;
    pix_out_t dst_pixel;

    pix_in_t  rgb_backlog[$];
    pix_out_t expected_yuv[$];
    bit       matrix_on = 1'b0;
    bit       src_took = 1'b0;
    int       src_idle_pct = 0;
    int       dst_stall_pct = 0;
    int       error_count = 0;

    half_float_rgb_to_yuv_top i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .matrix_enable_we    (matrix_enable_we),
        .matrix_enable_wdata (matrix_enable_wdata),
        .src_valid           (src_valid),
        .src_stall           (src_stall),
        .src_pixel           (src_pixel),
        .dst_valid           (dst_valid),
        .dst_stall           (dst_stall),
        .dst_pixel           (dst_pixel)
    );

    initial
    begin
        forever #HALF_PERIOD clk = ~clk;
    end

    // Binary16 to signed Q16 times 255; magnitude truncated, sign applied after
    function automatic longint half_to_scaled(input logic [15:0] h, output bit is_nan);
        longint mant;
        longint mag;
        int     expo;
        is_nan = 1'b0;
        expo = int'(h[14:10]);
        if (expo == 31)
        begin
            is_nan = (h[9:0] != 10'd0);
            mag = is_nan ? 0 : INF_Q16;
        end
        else
        begin
            if (expo == 0)
            begin
                mant = longint'(h[9:0]);
                expo = 1;
            end
            else
            begin
                mant = longint'(h[9:0]) + 1024;
            end
            mant = mant * 255;
            if (expo >= 9)
                mag = mant << (expo - 9);
            else
                mag = mant >> (9 - expo);
        end
        return h[15] ? -mag : mag;
    endfunction

    // Saturate to 0..255 and drop the fraction bits
    function automatic logic [7:0] clamp_to_byte(input longint v, input int frac_bits);
        if (v <= 0)
            return 8'd0;
        if (v >= (longint'(255) << frac_bits))
            return 8'd255;
        return 8'(v >> frac_bits);
    endfunction

    // Expected Y/U/V for one pixel under the current matrix setting
    function automatic pix_out_t predict_yuv(input pix_in_t px, input bit use_matrix);
        pix_out_t res;
        longint   r;
        longint   g;
        longint   b;
        bit       nr;
        bit       ng;
        bit       nb;
        r = half_to_scaled(px.red_half, nr);
        g = half_to_scaled(px.green_half, ng);
        b = half_to_scaled(px.blue_half, nb);
        if (use_matrix)
        begin
            if (nr || ng || nb)
            begin
                res = '0;
            end
            else
            begin
                res.luma        = clamp_to_byte(Y_R * r + Y_G * g + Y_B * b + Y_OFS_Q32,
                                                FRAC_Q32);
                res.chroma_blue = clamp_to_byte(CB_R * r + CB_G * g + CB_B * b + C_OFS_Q32,
                                                FRAC_Q32);
                res.chroma_red  = clamp_to_byte(CR_R * r + CR_G * g + CR_B * b + C_OFS_Q32,
                                                FRAC_Q32);
            end
        end
        else
        begin
            res.luma        = nr ? 8'd0 : clamp_to_byte(r, FRAC_Q16);
            res.chroma_blue = ng ? 8'd0 : clamp_to_byte(g, FRAC_Q16);
            res.chroma_red  = nb ? 8'd0 : clamp_to_byte(b, FRAC_Q16);
        end
        return res;
    endfunction

    // Random channel value, mostly in the nominal 0..1 range
    function automatic logic [15:0] rand_half();
        logic [15:0] h;
        int          k;
        k = $urandom_range(99);
        if (k < 65)
            h = {1'b0, 5'($urandom_range(14)), 10'($urandom)};
        else if (k < 72)
            h = $urandom_range(1) ? H_ONE : H_ZERO;
        else if (k < 80)
            h = {1'b1, 5'($urandom_range(14)), 10'($urandom)};
        else if (k < 87)
            h = {1'b0, 5'($urandom_range(30, 15)), 10'($urandom)};
        else if (k < 93)
            h = {1'($urandom), 5'd31, $urandom_range(1) ? 10'($urandom) : 10'd0};
        else
            h = 16'($urandom);
        return h;
    endfunction

    // Source driver: hold a stalled transfer, otherwise load the next pixel or idle
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
        end
        else if (!src_valid || src_took)
        begin
            if (rgb_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                src_pixel <= rgb_backlog.pop_front();
                src_valid <= 1'b1;
            end
            else
            begin
                src_valid <= 1'b0;
            end
        end
    end

    // Sink back-pressure
    always @(negedge clk)
    begin
        dst_stall <= rst_n && ($urandom_range(99) < dst_stall_pct);
    end

    // Monitor: predict on input transfers, check on output transfers
    always @(posedge clk)
    begin
        pix_out_t want;
        src_took = rst_n && src_valid && !src_stall;
        if (src_took)
            expected_yuv.push_back(predict_yuv(src_pixel, matrix_on));
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (expected_yuv.size() == 0)
            begin
                $error("unexpected output transfer: luma %0d chroma_blue %0d chroma_red %0d",
                       dst_pixel.luma, dst_pixel.chroma_blue, dst_pixel.chroma_red);
                error_count++;
            end
            else
            begin
                want = expected_yuv.pop_front();
                if (dst_pixel.luma !== want.luma)
                begin
                    $error("luma: expected %0d, actual %0d", want.luma, dst_pixel.luma);
                    error_count++;
                end
                if (dst_pixel.chroma_blue !== want.chroma_blue)
                begin
                    $error("chroma_blue: expected %0d, actual %0d",
                           want.chroma_blue, dst_pixel.chroma_blue);
                    error_count++;
                end
                if (dst_pixel.chroma_red !== want.chroma_red)
                begin
                    $error("chroma_red: expected %0d, actual %0d",
                           want.chroma_red, dst_pixel.chroma_red);
                    error_count++;
                end
            end
        end
    end

    // Register write, only issued while the pipeline is empty
    task automatic write_matrix_enable(input bit value);
        @(negedge clk);
        matrix_enable_we <= 1'b1;
        matrix_enable_wdata <= value;
        matrix_on = value;
        @(negedge clk);
        matrix_enable_we <= 1'b0;
    endtask

    // Wait until every queued pixel has been sent and every result has come back
    task automatic wait_drained();
        while (rgb_backlog.size() != 0 || src_valid || expected_yuv.size() != 0)
            @(posedge clk);
    endtask

    task automatic queue_pixel(input logic [15:0] r, input logic [15:0] g,
                               input logic [15:0] b);
        pix_in_t px;
        px.red_half = r;
        px.green_half = g;
        px.blue_half = b;
        rgb_backlog.push_back(px);
    endtask

    task automatic queue_random(input int count);
        repeat (count)
            queue_pixel(rand_half(), rand_half(), rand_half());
    endtask

    // Corner pixels: primaries, extremes, subnormals, signed zero, infinities, NaNs
    task automatic queue_directed();
        queue_pixel(H_ZERO, H_ZERO, H_ZERO);
        queue_pixel(H_ONE, H_ONE, H_ONE);
        queue_pixel(H_ONE, H_ZERO, H_ZERO);
        queue_pixel(H_ZERO, H_ONE, H_ZERO);
        queue_pixel(H_ZERO, H_ZERO, H_ONE);
        queue_pixel(H_MAX, H_NEG_MAX, H_SUB_MIN);
        queue_pixel(H_INF, H_NEG_INF, H_SUB_MAX);
        queue_pixel(H_NEG_INF, H_INF, H_NEG_ZERO);
        queue_pixel(H_QNAN, H_HALF, H_QUARTER);
        queue_pixel(H_HALF, H_NEG_NAN, H_HALF);
        queue_pixel(H_HALF, H_HALF, H_SNAN);
        queue_pixel(H_ALL_ONES, H_SUB_NEG, H_255);
        queue_pixel(H_INF, H_ZERO, H_NEG_INF);
    endtask

    // Stimulus sequence
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sender idles often, receiver stalls more: directed pixels in both modes,
        // then random pixels with a pause until drained
        src_idle_pct = 38;
        dst_stall_pct = 64;
        write_matrix_enable(1'b0);
        queue_directed();
        wait_drained();
        write_matrix_enable(1'b1);
        queue_directed();
        wait_drained();
        queue_random(400);
        wait_drained();
        queue_random(300);
        wait_drained();

        // Roles swapped, pass-through mode
        src_idle_pct = 64;
        dst_stall_pct = 38;
        write_matrix_enable(1'b0);
        queue_random(500);
        wait_drained();

        // Full rate in both modes
        src_idle_pct = 0;
        dst_stall_pct = 0;
        write_matrix_enable(1'b1);
        queue_random(450);
        wait_drained();
        write_matrix_enable(1'b0);
        queue_random(350);
        wait_drained();

        // Catch stray results after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
